// File: src/tle_pkg.sv
`timescale 1ns / 1ps

package tle_pkg;

	// Request: one key byte or one line read
	typedef struct packed {
		logic       op;
		logic [7:0] key;
		logic [3:0] read_index;
	} cmd_t;

	// Result: echo, bell, read data or newline
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [3:0] line_length;
		logic       last;
	} rsp_t;

	// Request operations
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_ECHO    = 2'd0;
	localparam logic [1:0] KIND_BELL    = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;
	localparam logic [1:0] KIND_NEWLINE = 2'd3;

	// Character codes
	localparam logic [7:0] CH_CTRL_C = 8'h03;
	localparam logic [7:0] CH_BELL   = 8'h07;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	// Echo for control-C: " **^C**" and newline
	localparam logic [7:0] CTLC_ECHO [8] = '{
		8'h20, 8'h2A, 8'h2A, 8'h5E, 8'h43, 8'h2A, 8'h2A, 8'h0A
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	// Kind of result sequence being streamed out
	typedef enum logic [1:0] {
		SEQ_SINGLE,
		SEQ_CTLC,
		SEQ_ERASE
	} seq_t;

endpackage

// File: src/terminal_line_editor.sv
`timescale 1ns / 1ps

// Line editor for a serial console. Each key request (but an LF straight after a
// CR, which is swallowed) updates a command line of up to LINE_LEN-1 characters
// held in a small synchronous RAM and streams its echo, bell or newline results;
// a read request returns one stored byte. A request is decoded and registered as
// it is taken (a read also fetches its byte from the RAM then). Its results are
// then loaded into the output register one by one while rsp_stall is low. The
// next request is taken once the final result of the current one is in the
// output register. Control-C streams eight results, and ESC streams three per
// character held.
module terminal_line_editor
	import tle_pkg::*;
#(
	parameter int LINE_LEN = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW        = $clog2(LINE_LEN);
	localparam int ERASE_MAX = 3 * (LINE_LEN - 1);
	localparam int REM_MAX   = (ERASE_MAX > 8) ? ERASE_MAX : 8;
	localparam int RW        = $clog2(REM_MAX + 1);

	state_t state_q, state_d;
	seq_t   seq_q;
	logic [RW-1:0] rem_q;
	logic [2:0]    ctlc_idx_q;
	logic [1:0]    phase_q;
	logic [1:0]    kind_q;
	logic [7:0]    byte_q;
	logic          hit_q;
	logic [7:0]    rd_data_q;
	logic [AW-1:0] count_q;
	logic          prev_cr_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [7:0] line_mem_q [LINE_LEN];

	logic accept, slot_free, load, emit_valid;
	rsp_t emit;

	// Decoded request
	logic [7:0]    dec_c, dec_p;
	logic          dec_swallow, dec_cr, dec_wr;
	seq_t          dec_seq;
	logic [RW-1:0] dec_rem;
	logic [1:0]    dec_kind;
	logic [7:0]    dec_byte;
	logic [AW-1:0] dec_count;
	logic [AW+3:0] idx_w, cnt_w;
	logic          dec_hit;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign load      = emit_valid && slot_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign idx_w   = {{AW{1'b0}}, cmd.read_index};
	assign cnt_w   = {4'b0, count_q};
	assign dec_hit = (idx_w < cnt_w);

	// Key decode
	always_comb begin
		dec_swallow = prev_cr_q && (cmd.key == CH_LF);
		dec_cr      = (cmd.key == CH_CR);
		dec_c       = dec_cr ? CH_LF : cmd.key;
		dec_p       = (dec_c == CH_TAB) ? CH_SPACE : dec_c;
		dec_wr      = 1'b0;
		dec_seq     = SEQ_SINGLE;
		dec_rem     = RW'(1);
		dec_kind    = KIND_BELL;
		dec_byte    = CH_BELL;
		dec_count   = count_q;
		if (dec_c == CH_CTRL_C) begin
			dec_seq   = SEQ_CTLC;
			dec_rem   = RW'(8);
			dec_count = '0;
		end else if (dec_c == CH_ESC) begin
			if (count_q != '0) begin
				dec_seq   = SEQ_ERASE;
				dec_rem   = RW'({count_q, 1'b0}) + RW'(count_q);
				dec_count = '0;
			end
		end else if (dec_c == CH_BS || dec_c == CH_DEL) begin
			if (count_q != '0) begin
				dec_seq   = SEQ_ERASE;
				dec_rem   = RW'(3);
				dec_count = count_q - AW'(1);
			end
		end else if (dec_c == CH_LF) begin
			dec_kind = KIND_NEWLINE;
			dec_byte = CH_LF;
		end else if (dec_p >= CH_SPACE && dec_p < CH_DEL
				&& count_q != AW'(LINE_LEN - 1)) begin
			dec_wr    = 1'b1;
			dec_kind  = KIND_ECHO;
			dec_byte  = dec_p;
			dec_count = count_q + AW'(1);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.op == OP_READ)
						state_d = ST_READ;
					else if (!dec_swallow)
						state_d = ST_EMIT;
				end
			end
			ST_READ: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (slot_free && rem_q == RW'(1))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Result under construction
	always_comb begin
		emit_valid       = 1'b0;
		emit.kind        = KIND_ECHO;
		emit.data_byte   = byte_q;
		emit.line_length = cnt_w[3:0];
		emit.last        = 1'b1;
		unique case (state_q)
			ST_IDLE: ;
			ST_READ: begin
				emit_valid     = 1'b1;
				emit.kind      = KIND_READ;
				emit.data_byte = hit_q ? rd_data_q : 8'h00;
			end
			ST_EMIT: begin
				emit_valid = 1'b1;
				emit.last  = (rem_q == RW'(1));
				unique case (seq_q)
					SEQ_SINGLE: begin
						emit.kind      = kind_q;
						emit.data_byte = byte_q;
					end
					SEQ_CTLC:  emit.data_byte = CTLC_ECHO[ctlc_idx_q];
					SEQ_ERASE: emit.data_byte = (phase_q == 2'd1) ? CH_SPACE : CH_BS;
					default:   emit.data_byte = byte_q;
				endcase
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			prev_cr_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && cmd.op == OP_KEY) begin
				prev_cr_q <= dec_swallow ? 1'b0 : dec_cr;
				if (!dec_swallow)
					count_q <= dec_count;
			end
			if (load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// Sequence registers and output register
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q      <= dec_seq;
			rem_q      <= dec_rem;
			kind_q     <= dec_kind;
			byte_q     <= dec_byte;
			hit_q      <= dec_hit;
			ctlc_idx_q <= '0;
			phase_q    <= '0;
		end else if (load) begin
			rem_q      <= rem_q - RW'(1);
			ctlc_idx_q <= ctlc_idx_q + 3'd1;
			phase_q    <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
		end
		if (load)
			rsp_q <= emit;
	end

	// Line RAM: append writes at the fill count, reads registered
	always_ff @(posedge clk) begin
		if (accept && cmd.op == OP_KEY && !dec_swallow && dec_wr)
			line_mem_q[count_q] <= dec_p;
		if (accept && cmd.op == OP_READ)
			rd_data_q <= line_mem_q[idx_w[AW-1:0]];
	end

endmodule

// File: src/tle_checker.sv
`timescale 1ns / 1ps

module tle_checker
	import tle_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// Read data is always a single final result
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_READ |-> rsp.last)
		else $error("read result not last");

	// Bell carries the bell code and ends the request
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_BELL |-> rsp.data_byte == CH_BELL && rsp.last)
		else $error("bad bell result");

	// Newline echo carries LF and ends the request
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_NEWLINE |-> rsp.data_byte == CH_LF && rsp.last)
		else $error("bad newline result");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (.*);
